FILE: src/bit_field_and_byte_shuffle_unit_assert.svh
// Assertion macros shared by the bit-field and byte-shuffle unit checkers.
`ifndef BIT_FIELD_AND_BYTE_SHUFFLE_UNIT_ASSERT_SVH
`define BIT_FIELD_AND_BYTE_SHUFFLE_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define BFBSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BFBSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bfbsu_pkg.sv
// Shared types and constants of the bit-field and byte-shuffle unit.
package bfbsu_pkg;

    typedef enum logic [3:0] {
        CMD_EXT      = 4'd0,
        CMD_INS      = 4'd1,
        CMD_BITSWAP  = 4'd2,
        CMD_WSBH     = 4'd3,
        CMD_ALIGN    = 4'd4,
        CMD_SEB      = 4'd5,
        CMD_SEH      = 4'd6,
        CMD_DBITSWAP = 4'd7,
        CMD_DSBH     = 4'd8,
        CMD_DSHD     = 4'd9,
        CMD_DALIGN   = 4'd10,
        CMD_RDHWR    = 4'd11
    } t_cmd;

    // Highest hardware register number of the low group that reads as zero.
    localparam logic [4:0] HWR_LOW_LAST = 5'd3;
    // User local register, also reads as zero.
    localparam logic [4:0] HWR_ULR      = 5'd29;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [63:0] source_value;
        logic [63:0] target_value;
        logic [4:0]  position_field;
        logic [4:0]  size_field;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_value;
        logic        reserved_instruction;
    } t_out_item;

endpackage

FILE: src/bfbsu_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
interface bfbsu_chan_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/bfbsu_core.sv
// Combinational datapath: decodes one item and forms its result.
module bfbsu_core (
    input  bfbsu_pkg::t_in_item  i_item,
    output bfbsu_pkg::t_out_item o_item
);
    import bfbsu_pkg::*;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] rev_bits_in_bytes(input logic [63:0] v);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            for (int k = 0; k < 8; k++) begin
                r[8*b + k] = v[8*b + 7 - k];
            end
        end
        return r;
    endfunction

    logic [63:0]  rs;
    logic [63:0]  rt;
    logic [4:0]   pos;
    logic [4:0]   sz;
    logic [31:0]  ext_mask;
    logic [4:0]   ins_msbd;
    logic [31:0]  ins_mask;
    logic [63:0]  align_cat;
    logic [127:0] dalign_cat;
    logic [63:0]  swapped;

    assign rs  = i_item.source_value;
    assign rt  = i_item.target_value;
    assign pos = i_item.position_field;
    assign sz  = i_item.size_field;

    // EXT keeps msbd+1 bits; field bits past bit 31 read as zero.
    assign ext_mask = 32'hFFFF_FFFF >> (5'd31 - sz);

    // INS mask covers msb..lsb, empty when msb is below lsb.
    assign ins_msbd = sz - pos;
    assign ins_mask = (sz >= pos) ? ((32'hFFFF_FFFF >> (5'd31 - ins_msbd)) << pos) : 32'd0;

    // ALIGN and DALIGN take the upper half of {rt, rs} shifted by whole bytes.
    assign align_cat  = {rt[31:0], rs[31:0]} << {pos[1:0], 3'b000};
    assign dalign_cat = {rt, rs} << {pos[2:0], 3'b000};

    assign swapped = rev_bits_in_bytes(rt);

    always_comb begin
        o_item = '0;
        case (i_item.cmd)
            CMD_EXT: begin
                o_item.result_value = sext32((rs[31:0] >> pos) & ext_mask);
            end
            CMD_INS: begin
                o_item.result_value = sext32((rt[31:0] & ~ins_mask) |
                                             ((rs[31:0] << pos) & ins_mask));
            end
            CMD_BITSWAP: begin
                o_item.result_value = sext32(swapped[31:0]);
            end
            CMD_WSBH: begin
                o_item.result_value = sext32({rt[23:16], rt[31:24], rt[7:0], rt[15:8]});
            end
            CMD_ALIGN: begin
                o_item.result_value = sext32(align_cat[63:32]);
            end
            CMD_SEB: begin
                o_item.result_value = {{56{rt[7]}}, rt[7:0]};
            end
            CMD_SEH: begin
                o_item.result_value = {{48{rt[15]}}, rt[15:0]};
            end
            CMD_DBITSWAP: begin
                o_item.result_value = swapped;
            end
            CMD_DSBH: begin
                o_item.result_value = {rt[55:48], rt[63:56], rt[39:32], rt[47:40],
                                       rt[23:16], rt[31:24], rt[7:0],   rt[15:8]};
            end
            CMD_DSHD: begin
                o_item.result_value = {rt[15:0], rt[31:16], rt[47:32], rt[63:48]};
            end
            CMD_DALIGN: begin
                o_item.result_value = dalign_cat[127:64];
            end
            CMD_RDHWR: begin
                o_item.reserved_instruction = !((sz <= HWR_LOW_LAST) || (sz == HWR_ULR));
            end
            default: begin
                o_item.reserved_instruction = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/bit_field_and_byte_shuffle_unit.sv
// Top level of the bit-field and byte-shuffle execution unit.
//
// Executes the SPECIAL3 bit-field and byte-shuffle group (EXT, INS,
// BITSWAP, WSBH, ALIGN, SEB, SEH, DBITSWAP, DSBH, DSHD, DALIGN) plus RDHWR
// of hardware registers 0-3 and 29, which read as zero. Any other hardware
// register, and operation codes 12 to 15, return a zero result with
// reserved_instruction set. 32-bit operations are sign-extended from bit 31.
// One item is taken per clock while the result side is not stalled; each
// item passes through the input register and then the result register, so
// a result is presented once the result register has loaded it and can
// transfer while o_out.ready is high. Besides output back-pressure, the
// two-stage register pipeline is the only limit: the whole computation is
// shifts, masks and a result mux between those registers.
// A stalled result holds in the result register while the input register
// still takes a new item, so the input side keeps moving until both stages
// are full. Reset is synchronous and active low; it only empties the stages.
module bit_field_and_byte_shuffle_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bfbsu_chan_if.sink   i_in,
    bfbsu_chan_if.source o_out
);
    import bfbsu_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      adv_out;
    logic      adv_in;

    // Advance the result stage when it is empty or its transfer completes;
    // advance the input stage when it is empty or can move down.
    assign adv_out = !r_out_valid || o_out.ready;
    assign adv_in  = !r_in_valid || adv_out;

    assign i_in.ready    = adv_in;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    bfbsu_core u_core (
        .i_item (r_in_item),
        .o_item (n_out_item)
    );

    // Input register: capture a new transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_in.valid;
        end
        if (adv_in && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    // Result register: load the computed item, hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
        if (adv_out && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

FILE: src/bfbsu_checker.sv
// Port-level checker for the bit-field and byte-shuffle unit, with its bind.
`include "bit_field_and_byte_shuffle_unit_assert.svh"

module bfbsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_result,
    input logic        i_out_reserved
);

    `BFBSU_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `BFBSU_ASSERT(a_reserved_zero, i_clk, i_rst_n,
        i_out_valid && i_out_reserved |-> i_out_result == 64'd0,
        "reserved instruction with nonzero result")
    `BFBSU_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !i_out_valid |-> i_in_ready, "input stalled with empty result stage")
    `BFBSU_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> !i_out_valid, "result valid right after reset")

endmodule

bind bit_field_and_byte_shuffle_unit bfbsu_checker u_bfbsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_result   (o_out.payload.result_value),
    .i_out_reserved (o_out.payload.reserved_instruction)
);
